// ===== sv/ctg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_pkg
// shared widths, types and states of the cubic trajectory generator
// ----------------------------------------------------------------------------
package ctg_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int TICK_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int S_WIDTH    = FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(FRAC_BITS);
    localparam int DIFF_W     = POS_WIDTH + 1;
    localparam int PROD_W     = DIFF_W + S_WIDTH;
    localparam int Q_W        = PROD_W - FRAC_BITS;
    localparam int SQ_W       = 2 * FRAC_BITS;
    localparam int CUBE_W     = 3 * FRAC_BITS;
    localparam int POLY_W     = 3 * FRAC_BITS + 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POLY,
        ST_BLEND,
        ST_DONE
    } ctg_state_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] desired_x;
        logic signed [POS_WIDTH-1:0] desired_y;
        logic signed [POS_WIDTH-1:0] desired_z;
        logic                        accepted;
        logic                        moving;
    } ctg_result_t;

endpackage
`default_nettype wire

// ===== sv/ctg_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_in_if
// request channel: tick with measured position or start of a move
// ----------------------------------------------------------------------------
interface ctg_in_if import ctg_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic [TICK_WIDTH-1:0]       duration_ticks;

    modport source (
        output valid,
        output command,
        output pos_x,
        output pos_y,
        output pos_z,
        output duration_ticks,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  pos_x,
        input  pos_y,
        input  pos_z,
        input  duration_ticks,
        output ready
    );

endinterface
`default_nettype wire

// ===== sv/ctg_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_out_if
// setpoint channel: commanded position and move status
// ----------------------------------------------------------------------------
interface ctg_out_if import ctg_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] desired_x;
    logic signed [POS_WIDTH-1:0] desired_y;
    logic signed [POS_WIDTH-1:0] desired_z;
    logic                        accepted;
    logic                        moving;

    modport source (
        output valid,
        output desired_x,
        output desired_y,
        output desired_z,
        output accepted,
        output moving,
        input  ready
    );

    modport sink (
        input  valid,
        input  desired_x,
        input  desired_y,
        input  desired_z,
        input  accepted,
        input  moving,
        output ready
    );

endinterface
`default_nettype wire

// ===== sv/ctg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_div
// restoring divider, one quotient bit per cycle: u = floor(num * 2^16 / den)
// with num below den
// ----------------------------------------------------------------------------
module ctg_div import ctg_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [TICK_WIDTH-1:0] num,
    input  wire logic [TICK_WIDTH-1:0] den,
    output logic                       done,
    output logic [FRAC_BITS-1:0]       quo
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TICK_WIDTH-1:0] rem_reg;
    logic [TICK_WIDTH-1:0] den_reg;
    logic [FRAC_BITS-1:0]  quo_reg;
    logic [TICK_WIDTH:0]   rem_shift;
    logic [TICK_WIDTH:0]   rem_sub;
    logic                  fits;
    logic [TICK_WIDTH-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
        rem_next  = fits ? rem_sub[TICK_WIDTH-1:0] : rem_shift[TICK_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== sv/ctg_smooth.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_smooth
// smoothstep polynomial s = 3u^2 - 2u^3 in Q1.16, three registered stages
// ----------------------------------------------------------------------------
module ctg_smooth import ctg_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [FRAC_BITS-1:0] u,
    output logic                      done,
    output logic [S_WIDTH-1:0]        s
);

    logic [2:0]           vld_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [FRAC_BITS-1:0] u_d1_reg;
    logic [CUBE_W-1:0]    cube_reg;
    logic [SQ_W-1:0]      sq_d2_reg;
    logic [S_WIDTH-1:0]   s_reg;
    logic [POLY_W-1:0]    term_sq;
    logic [POLY_W-1:0]    term_cube;
    logic [POLY_W-1:0]    poly;

    always_comb
    begin
        term_sq   = ((POLY_W'(sq_d2_reg) << 1) + POLY_W'(sq_d2_reg)) << FRAC_BITS;
        term_cube = POLY_W'(cube_reg) << 1;
        poly      = term_sq - term_cube;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg    <= SQ_W'(u) * SQ_W'(u);
        u_d1_reg  <= u;
        cube_reg  <= CUBE_W'(sq_reg) * CUBE_W'(u_d1_reg);
        sq_d2_reg <= sq_reg;
        s_reg     <= poly[SQ_W +: S_WIDTH];
    end

    assign done = vld_reg[2];
    assign s    = s_reg;

endmodule
`default_nettype wire

// ===== sv/ctg_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_lane
// one axis: pos + floor((goal - pos) * s / 2^16), three registered stages
// ----------------------------------------------------------------------------
module ctg_lane import ctg_pkg::*; (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [POS_WIDTH-1:0] pos,
    input  wire logic signed [POS_WIDTH-1:0] goal,
    input  wire logic [S_WIDTH-1:0]          s,
    output logic                             done,
    output logic signed [POS_WIDTH-1:0]      res
);

    logic [2:0]                  vld_reg;
    logic [DIFF_W-1:0]           diff_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic                        neg_reg;
    logic signed [POS_WIDTH-1:0] res_reg;
    logic                        neg;
    logic [DIFF_W-1:0]           mag;
    logic [Q_W-1:0]              q;
    logic [Q_W-1:0]              pos_ext;
    logic [Q_W-1:0]              sum;

    always_comb
    begin
        neg     = diff_reg[DIFF_W-1];
        mag     = neg ? (~diff_reg + 1'b1) : diff_reg;
        q       = prod_reg[PROD_W-1:FRAC_BITS]
                + Q_W'(neg_reg && (prod_reg[FRAC_BITS-1:0] != '0));
        pos_ext = {{(Q_W-POS_WIDTH){pos[POS_WIDTH-1]}}, pos};
        sum     = neg_reg ? (pos_ext - q) : (pos_ext + q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= {goal[POS_WIDTH-1], goal} - {pos[POS_WIDTH-1], pos};
        prod_reg <= PROD_W'(mag) * PROD_W'(s);
        neg_reg  <= neg;
        res_reg  <= sum[POS_WIDTH-1:0];
    end

    assign done = vld_reg[2];
    assign res  = res_reg;

endmodule
`default_nettype wire

// ===== sv/cubic_trajectory_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_trajectory_generator_core
// three-axis smoothstep move generator: shared divider and polynomial unit,
// one blend lane per axis, result merge into the output register
//
//   channel   modport   payload
//   request   sink      command, pos_x, pos_y, pos_z, duration_ticks
//   setpoint  source    desired_x, desired_y, desired_z, accepted, moving
//
// start items, idle and ending ticks: result register, then output register
// interpolating ticks: 16-step restoring divider, polynomial unit, blend lanes
// one item at a time; request.ready is high only in the idle state
// a finished result waits in the output register while the next item works
// rst_n clears the move state and the goals to zero, idle
// ----------------------------------------------------------------------------
module cubic_trajectory_generator_core import ctg_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctg_in_if.sink     request,
    ctg_out_if.source  setpoint
);

    ctg_state_t                  state_reg;
    ctg_state_t                  state_next;
    logic signed [POS_WIDTH-1:0] goal_x_reg;
    logic signed [POS_WIDTH-1:0] goal_y_reg;
    logic signed [POS_WIDTH-1:0] goal_z_reg;
    logic signed [POS_WIDTH-1:0] meas_x_reg;
    logic signed [POS_WIDTH-1:0] meas_y_reg;
    logic signed [POS_WIDTH-1:0] meas_z_reg;
    logic [TICK_WIDTH-1:0]       len_reg;
    logic [TICK_WIDTH-1:0]       elapsed_reg;
    logic                        active_reg;
    ctg_result_t                 res_reg;
    ctg_result_t                 out_reg;
    logic                        out_valid_reg;

    logic                        in_xfer;
    logic                        out_xfer;
    logic                        out_load;
    logic                        start_ok;
    logic [TICK_WIDTH-1:0]       elapsed_inc;
    logic                        move_ends;
    logic                        div_start;
    logic                        div_done;
    logic [FRAC_BITS-1:0]        u;
    logic                        poly_done;
    logic [S_WIDTH-1:0]          s;
    logic                        done_x;
    logic                        done_y;
    logic                        done_z;
    logic                        lanes_done;
    logic signed [POS_WIDTH-1:0] lane_x;
    logic signed [POS_WIDTH-1:0] lane_y;
    logic signed [POS_WIDTH-1:0] lane_z;

    always_comb
    begin
        in_xfer     = request.valid && (state_reg == ST_IDLE);
        out_xfer    = out_valid_reg && setpoint.ready;
        out_load    = (state_reg == ST_DONE) && (!out_valid_reg || setpoint.ready);
        start_ok    = !request.pos_z[POS_WIDTH-1] && (request.pos_z != '0)
                      && (request.duration_ticks != '0);
        elapsed_inc = (elapsed_reg != '1) ? (elapsed_reg + 1'b1) : elapsed_reg;
        move_ends   = (elapsed_inc >= len_reg);
        div_start   = in_xfer && !request.command && active_reg && !move_ends;
        lanes_done  = done_x && done_y && done_z;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = div_start ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_POLY;
                end
            end
            ST_POLY:
            begin
                if (poly_done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (lanes_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            goal_z_reg    <= '0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                if (request.command)
                begin
                    goal_x_reg <= request.pos_x;
                    goal_y_reg <= request.pos_y;
                    goal_z_reg <= request.pos_z;
                    len_reg    <= request.duration_ticks;
                    if (start_ok)
                    begin
                        active_reg  <= 1'b1;
                        elapsed_reg <= '0;
                    end
                end
                else if (active_reg)
                begin
                    elapsed_reg <= elapsed_inc;
                    if (move_ends)
                    begin
                        active_reg <= 1'b0;
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result staging: the merge of the three lanes or the goals
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            meas_x_reg <= request.pos_x;
            meas_y_reg <= request.pos_y;
            meas_z_reg <= request.pos_z;
            if (request.command)
            begin
                res_reg.desired_x <= request.pos_x;
                res_reg.desired_y <= request.pos_y;
                res_reg.desired_z <= request.pos_z;
                res_reg.accepted  <= start_ok;
                res_reg.moving    <= start_ok || active_reg;
            end
            else
            begin
                res_reg.desired_x <= goal_x_reg;
                res_reg.desired_y <= goal_y_reg;
                res_reg.desired_z <= goal_z_reg;
                res_reg.accepted  <= 1'b0;
                res_reg.moving    <= active_reg && !move_ends;
            end
        end
        else if ((state_reg == ST_BLEND) && lanes_done)
        begin
            res_reg.desired_x <= lane_x;
            res_reg.desired_y <= lane_y;
            res_reg.desired_z <= lane_z;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    ctg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (elapsed_inc),
        .den   (len_reg),
        .done  (div_done),
        .quo   (u)
    );

    ctg_smooth u_smooth (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_done),
        .u     (u),
        .done  (poly_done),
        .s     (s)
    );

    ctg_lane u_lane_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (poly_done),
        .pos   (meas_x_reg),
        .goal  (goal_x_reg),
        .s     (s),
        .done  (done_x),
        .res   (lane_x)
    );

    ctg_lane u_lane_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (poly_done),
        .pos   (meas_y_reg),
        .goal  (goal_y_reg),
        .s     (s),
        .done  (done_y),
        .res   (lane_y)
    );

    ctg_lane u_lane_z (
        .clk   (clk),
        .rst_n (rst_n),
        .start (poly_done),
        .pos   (meas_z_reg),
        .goal  (goal_z_reg),
        .s     (s),
        .done  (done_z),
        .res   (lane_z)
    );

    assign request.ready      = (state_reg == ST_IDLE);
    assign setpoint.valid     = out_valid_reg;
    assign setpoint.desired_x = out_reg.desired_x;
    assign setpoint.desired_y = out_reg.desired_y;
    assign setpoint.desired_z = out_reg.desired_z;
    assign setpoint.accepted  = out_reg.accepted;
    assign setpoint.moving    = out_reg.moving;

endmodule
`default_nettype wire
